/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the lexer RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/cstl_pkg.sv */
// Types, token codes and character helpers for the C subset lexer.
// Used by cstl_front, cstl_fifo, cstl_back and the top level.
package cstl_pkg;

  localparam logic [4:0] K_NUM    = 5'd0;
  localparam logic [4:0] K_IDENT  = 5'd1;
  localparam logic [4:0] K_INT    = 5'd2;
  localparam logic [4:0] K_PLUS   = 5'd7;
  localparam logic [4:0] K_MINUS  = 5'd8;
  localparam logic [4:0] K_STAR   = 5'd9;
  localparam logic [4:0] K_SLASH  = 5'd10;
  localparam logic [4:0] K_EQEQ   = 5'd11;
  localparam logic [4:0] K_NE     = 5'd12;
  localparam logic [4:0] K_LT     = 5'd13;
  localparam logic [4:0] K_GT     = 5'd14;
  localparam logic [4:0] K_LE     = 5'd15;
  localparam logic [4:0] K_GE     = 5'd16;
  localparam logic [4:0] K_ASSIGN = 5'd17;
  localparam logic [4:0] K_LPAREN = 5'd18;
  localparam logic [4:0] K_RPAREN = 5'd19;
  localparam logic [4:0] K_LBRACE = 5'd20;
  localparam logic [4:0] K_RBRACE = 5'd21;
  localparam logic [4:0] K_SEMI   = 5'd22;
  localparam logic [4:0] K_COMMA  = 5'd23;
  localparam logic [4:0] K_STRING = 5'd24;
  localparam logic [4:0] K_END    = 5'd25;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  localparam int NUM_KW = 5;
  localparam logic [7:0] KW_LEN [NUM_KW] = '{8'd3, 8'd2, 8'd4, 8'd5, 8'd6};
  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
  };

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [4:0]  kind;
    logic [63:0] value;
    logic [7:0]  ch;
    logic        text;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } bundle_t;

  function automatic result_t tok(logic [4:0] kind, logic [63:0] value);
    result_t r;
    r.kind  = kind;
    r.value = value;
    r.ch    = 8'h00;
    r.text  = 1'b0;
    return r;
  endfunction

  function automatic result_t txt(logic [7:0] c);
    result_t r;
    r.kind  = K_NUM;
    r.value = 64'd0;
    r.ch    = c;
    r.text  = 1'b1;
    return r;
  endfunction

  // Appends a result; a third one in the same request is dropped.
  function automatic bundle_t bundle_add(bundle_t b, result_t r);
    bundle_t o;
    o = b;
    if (b.cnt == 2'd0) begin
      o.r0  = r;
      o.cnt = 2'd1;
    end else if (b.cnt == 2'd1) begin
      o.r1  = r;
      o.cnt = 2'd2;
    end
    return o;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F});
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c inside {CH_SPACE, CH_TAB, CH_NL, CH_CR});
  endfunction

  function automatic logic [4:0] single_kind(logic [7:0] c);
    logic [4:0] k;
    case (c)
      "+":      k = K_PLUS;
      "-":      k = K_MINUS;
      "*":      k = K_STAR;
      CH_SLASH: k = K_SLASH;
      CH_LT:    k = K_LT;
      CH_GT:    k = K_GT;
      CH_EQ:    k = K_ASSIGN;
      "(":      k = K_LPAREN;
      ")":      k = K_RPAREN;
      "{":      k = K_LBRACE;
      "}":      k = K_RBRACE;
      ";":      k = K_SEMI;
      ",":      k = K_COMMA;
      default:  k = K_END;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] double_kind(logic [7:0] c);
    logic [4:0] k;
    case (c)
      CH_EQ:   k = K_EQEQ;
      CH_BANG: k = K_NE;
      CH_LT:   k = K_LE;
      default: k = K_GE;
    endcase
    return k;
  endfunction

  // Clears the candidate bit of every keyword that the new character rules out.
  function automatic logic [4:0] kw_step(logic [4:0] mask, logic [7:0] len, logic [7:0] c);
    logic [4:0] m;
    m = mask;
    for (int k = 0; k < NUM_KW; k++) begin
      if (!(len < KW_LEN[k] && KW_TEXT[k][len[2:0]] == c)) m[k] = 1'b0;
    end
    return m;
  endfunction

  function automatic logic [4:0] ident_kind(logic [4:0] mask, logic [7:0] len);
    logic [4:0] kind;
    kind = K_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      if (mask[k] && len == KW_LEN[k]) kind = K_INT + 5'(k);
    end
    return kind;
  endfunction

endpackage

/* hw/rtl/cstl_front.sv */
// Front end of the lexer: holds the scan state and classifies each byte.
// Produces a bundle of up to two results per request; uses cstl_pkg.
`include "assert_macros.svh"
module cstl_front #(
  parameter int MAX_IDENT_CHARS  = 63,
  parameter int MAX_STRING_CHARS = 254
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              is_end,
  output logic              push_req,
  output cstl_pkg::bundle_t bundle
);

  typedef enum logic [3:0] {
    M_IDLE, M_NUM, M_IDENT, M_STR, M_ESC, M_SKIP, M_COMMENT, M_SLASH, M_OP
  } mode_t;

  localparam logic [7:0] IDENT_CUT = 8'(MAX_IDENT_CHARS);
  localparam logic [7:0] STR_CUT   = 8'(MAX_STRING_CHARS);

  mode_t       mode, mode_next;
  logic [7:0]  pending_char, pend_next;
  logic [63:0] number_accum, acc_next;
  logic [7:0]  text_length, len_next;
  logic [4:0]  kw_mask, mask_next;
  cstl_pkg::bundle_t b;
  logic        fresh;
  logic        str_add;
  logic [7:0]  str_ch;

  always_comb begin
    mode_next = mode;
    pend_next = pending_char;
    acc_next  = number_accum;
    len_next  = text_length;
    mask_next = kw_mask;
    b         = '0;
    fresh     = 1'b0;
    str_add   = 1'b0;
    str_ch    = in_byte;
    if (is_end) begin
      case (mode)
        M_NUM: b = cstl_pkg::bundle_add(b, cstl_pkg::tok(cstl_pkg::K_NUM, number_accum));
        M_IDENT: b = cstl_pkg::bundle_add(b, cstl_pkg::tok(
                       cstl_pkg::ident_kind(kw_mask, text_length), {56'd0, text_length}));
        M_STR, M_ESC: b = cstl_pkg::bundle_add(b,
                            cstl_pkg::tok(cstl_pkg::K_STRING, {56'd0, text_length}));
        M_SLASH: b = cstl_pkg::bundle_add(b, cstl_pkg::tok(cstl_pkg::K_SLASH, 64'd0));
        M_OP: b = cstl_pkg::bundle_add(b,
                    cstl_pkg::tok(cstl_pkg::single_kind(pending_char), 64'd0));
        default: begin
        end
      endcase
      b         = cstl_pkg::bundle_add(b, cstl_pkg::tok(cstl_pkg::K_END, 64'd0));
      mode_next = M_IDLE;
      pend_next = 8'h00;
      acc_next  = 64'd0;
      len_next  = 8'd0;
      mask_next = 5'h1F;
    end else begin
      case (mode)
        M_NUM: begin
          if (cstl_pkg::is_digit(in_byte)) begin
            acc_next = {number_accum[60:0], 3'b000} + {number_accum[62:0], 1'b0}
                     + {60'd0, in_byte[3:0]};
          end else begin
            b     = cstl_pkg::bundle_add(b, cstl_pkg::tok(cstl_pkg::K_NUM, number_accum));
            fresh = 1'b1;
          end
        end
        M_IDENT: begin
          if (cstl_pkg::is_alpha(in_byte) || cstl_pkg::is_digit(in_byte)) begin
            mask_next = cstl_pkg::kw_step(kw_mask, text_length, in_byte);
            len_next  = text_length + 8'd1;
            b         = cstl_pkg::bundle_add(b, cstl_pkg::txt(in_byte));
            if (len_next >= IDENT_CUT) begin
              b = cstl_pkg::bundle_add(b, cstl_pkg::tok(
                    cstl_pkg::ident_kind(mask_next, len_next), {56'd0, len_next}));
              mode_next = M_IDLE;
            end
          end else begin
            b = cstl_pkg::bundle_add(b, cstl_pkg::tok(
                  cstl_pkg::ident_kind(kw_mask, text_length), {56'd0, text_length}));
            fresh = 1'b1;
          end
        end
        M_STR: begin
          if (in_byte == cstl_pkg::CH_QUOTE) begin
            b = cstl_pkg::bundle_add(b,
                  cstl_pkg::tok(cstl_pkg::K_STRING, {56'd0, text_length}));
            mode_next = M_IDLE;
          end else if (in_byte == cstl_pkg::CH_BSLASH) begin
            mode_next = M_ESC;
          end else begin
            str_add = 1'b1;
          end
        end
        M_ESC: begin
          mode_next = M_STR;
          str_add   = 1'b1;
          if (in_byte == cstl_pkg::CH_LOW_N) str_ch = cstl_pkg::CH_NL;
          else if (in_byte == cstl_pkg::CH_LOW_T) str_ch = cstl_pkg::CH_TAB;
        end
        M_SKIP: mode_next = M_IDLE;
        M_COMMENT: begin
          if (in_byte == cstl_pkg::CH_NL) mode_next = M_IDLE;
        end
        M_SLASH: begin
          if (in_byte == cstl_pkg::CH_SLASH) begin
            mode_next = M_COMMENT;
          end else begin
            b     = cstl_pkg::bundle_add(b, cstl_pkg::tok(cstl_pkg::K_SLASH, 64'd0));
            fresh = 1'b1;
          end
        end
        M_OP: begin
          if (in_byte == cstl_pkg::CH_EQ) begin
            b = cstl_pkg::bundle_add(b,
                  cstl_pkg::tok(cstl_pkg::double_kind(pending_char), 64'd0));
            mode_next = M_IDLE;
          end else begin
            b = cstl_pkg::bundle_add(b,
                  cstl_pkg::tok(cstl_pkg::single_kind(pending_char), 64'd0));
            fresh = 1'b1;
          end
        end
        default: fresh = 1'b1;
      endcase

      if (str_add) begin
        b        = cstl_pkg::bundle_add(b, cstl_pkg::txt(str_ch));
        len_next = text_length + 8'd1;
        if (len_next >= STR_CUT) begin
          b = cstl_pkg::bundle_add(b, cstl_pkg::tok(cstl_pkg::K_STRING, {56'd0, len_next}));
          mode_next = M_SKIP;
        end
      end

      if (fresh) begin
        mode_next = M_IDLE;
        if (cstl_pkg::is_blank(in_byte)) begin
          mode_next = M_IDLE;
        end else if (in_byte == cstl_pkg::CH_SLASH) begin
          mode_next = M_SLASH;
        end else if (in_byte inside {cstl_pkg::CH_EQ, cstl_pkg::CH_BANG,
                                     cstl_pkg::CH_LT, cstl_pkg::CH_GT}) begin
          mode_next = M_OP;
          pend_next = in_byte;
        end else if (cstl_pkg::is_digit(in_byte)) begin
          mode_next = M_NUM;
          acc_next  = {60'd0, in_byte[3:0]};
        end else if (cstl_pkg::is_alpha(in_byte)) begin
          mode_next = M_IDENT;
          mask_next = cstl_pkg::kw_step(5'h1F, 8'd0, in_byte);
          len_next  = 8'd1;
          b         = cstl_pkg::bundle_add(b, cstl_pkg::txt(in_byte));
          if (len_next >= IDENT_CUT) begin
            b = cstl_pkg::bundle_add(b, cstl_pkg::tok(
                  cstl_pkg::ident_kind(mask_next, len_next), {56'd0, len_next}));
            mode_next = M_IDLE;
          end
        end else if (in_byte == cstl_pkg::CH_QUOTE) begin
          mode_next = M_STR;
          len_next  = 8'd0;
        end else begin
          b = cstl_pkg::bundle_add(b, cstl_pkg::tok(cstl_pkg::single_kind(in_byte), 64'd0));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      pending_char <= 8'h00;
      number_accum <= 64'd0;
      text_length  <= 8'd0;
      kw_mask      <= 5'h1F;
    end else if (accept) begin
      mode         <= mode_next;
      pending_char <= pend_next;
      number_accum <= acc_next;
      text_length  <= len_next;
      kw_mask      <= mask_next;
    end
  end

  assign bundle   = b;
  assign push_req = accept && (b.cnt != 2'd0);

  `ASSERT_IMPLIES(a_ident_len, clk, rst, mode == M_IDENT,
                  text_length != 8'd0 && text_length < IDENT_CUT)
  `ASSERT_IMPLIES(a_str_len, clk, rst, mode == M_STR || mode == M_ESC,
                  text_length < STR_CUT)

endmodule

/* hw/rtl/cstl_fifo.sv */
// Short queue of result bundles between the lexer front and back ends.
// Uses cstl_pkg for the bundle type and the depth.
`include "assert_macros.svh"
module cstl_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cstl_pkg::bundle_t din,
  output logic              full,
  input  logic              pop,
  output cstl_pkg::bundle_t dout,
  output logic              empty
);

  cstl_pkg::bundle_t           slots [cstl_pkg::Q_DEPTH];
  logic [cstl_pkg::Q_AW-1:0]   wr_ptr;
  logic [cstl_pkg::Q_AW-1:0]   rd_ptr;
  logic [cstl_pkg::Q_CW-1:0]   count;
  logic                        do_push;
  logic                        do_pop;

  assign full    = (count == cstl_pkg::Q_CW'(cstl_pkg::Q_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= din;
  end

  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1,
                  count <= cstl_pkg::Q_CW'(cstl_pkg::Q_DEPTH))
  `ASSERT_NEXT(a_fill_step, clk, rst, do_push && !do_pop, count == $past(count) + 1'b1)

endmodule

/* hw/rtl/cstl_back.sv */
// Back end of the lexer: hands out the results of each queued bundle in order.
// Reads bundles from cstl_fifo; uses cstl_pkg.
`include "assert_macros.svh"
module cstl_back (
  input  logic               clk,
  input  logic               rst,
  input  cstl_pkg::bundle_t  head,
  input  logic               head_empty,
  output logic               head_pop,
  input  logic               pop,
  output logic               empty,
  output logic [4:0]         token_kind,
  output logic signed [63:0] num_value,
  output logic [7:0]         text_char,
  output logic               is_text,
  output logic               last_of_run
);

  logic              slot;
  cstl_pkg::result_t cur;
  logic              last;

  assign cur         = slot ? head.r1 : head.r0;
  assign last        = slot || (head.cnt == 2'd1);
  assign empty       = head_empty;
  assign head_pop    = pop && !head_empty && last;
  assign token_kind  = cur.kind;
  assign num_value   = $signed(cur.value);
  assign text_char   = cur.ch;
  assign is_text     = cur.text;
  assign last_of_run = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= 1'b0;
    end else if (pop && !head_empty) begin
      slot <= !last;
    end
  end

  `ASSERT_IMPLIES(a_head_count, clk, rst, !head_empty, head.cnt == 2'd1 || head.cnt == 2'd2)
  `ASSERT_IMPLIES(a_second_slot, clk, rst, slot, !head_empty && head.cnt == 2'd2)

endmodule

/* hw/rtl/c_subset_token_lexer_unit.sv */
// Top level of the C subset token lexer: front end, bundle queue and back end.
// Depends on cstl_pkg, cstl_front, cstl_fifo and cstl_back.
//
//   Channel   Handshake        Payload
//   source    push / full      in_byte, is_end
//   tokens    pop / empty      token_kind, num_value, text_char, is_text, last_of_run
//
// One source byte is taken per cycle while the four-bundle queue has room.
// Each byte yields zero, one or two results; the back end hands out one per pop,
// so a byte with two results holds the token port for two pops.
// A result is written into the bundle queue when its byte is taken and reaches the
// token port once all earlier results have been popped. Reset is synchronous; no memory needs clearing.
module c_subset_token_lexer_unit #(
  parameter int MAX_IDENT_CHARS  = 63,
  parameter int MAX_STRING_CHARS = 254
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_byte,
  input  logic               is_end,
  output logic               empty,
  input  logic               pop,
  output logic [4:0]         token_kind,
  output logic signed [63:0] num_value,
  output logic [7:0]         text_char,
  output logic               is_text,
  output logic               last_of_run
);

  logic              accept;
  logic              q_push;
  cstl_pkg::bundle_t q_din;
  cstl_pkg::bundle_t q_head;
  logic              q_empty;
  logic              q_pop;

  assign accept = push && !full;

  cstl_front #(
    .MAX_IDENT_CHARS  (MAX_IDENT_CHARS),
    .MAX_STRING_CHARS (MAX_STRING_CHARS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (in_byte),
    .is_end   (is_end),
    .push_req (q_push),
    .bundle   (q_din)
  );

  cstl_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  cstl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .head_empty  (q_empty),
    .head_pop    (q_pop),
    .pop         (pop),
    .empty       (empty),
    .token_kind  (token_kind),
    .num_value   (num_value),
    .text_char   (text_char),
    .is_text     (is_text),
    .last_of_run (last_of_run)
  );

endmodule
